// ----- src/rds_pkg.sv -----
// ---------------------------------------------------------------------------
// Reclaim donor selector package
// Shared widths, constants and the item types that travel between stages.
// ---------------------------------------------------------------------------
package rds_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = 4;
  localparam int BYTE_W    = 32;
  localparam int PRIO_W    = 3;
  localparam int ACT_W     = 2;
  localparam int IMP_W     = 7;
  localparam int CEIL_W    = 8;

  localparam int unsigned PRIO_WEIGHT = 16;
  localparam int unsigned ACT_WEIGHT  = 4;

  // Ceiling value that turns the importance check off
  localparam logic [CEIL_W-1:0] CEILING_OFF = 8'hFF;

  // Raw client record as taken from the input channel
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              live;
    logic              skip;
    logic [PRIO_W-1:0] priority_level;
    logic [ACT_W-1:0]  activity_level;
    logic [BYTE_W-1:0] managed_bytes;
    logic [BYTE_W-1:0] observed_bytes;
    logic [BYTE_W-1:0] minimum_bytes;
    logic [BYTE_W-1:0] reclaimable_bytes;
    logic [BYTE_W-1:0] soft_limit_bytes;
    logic [CEIL_W-1:0] importance_ceiling;
    logic              last_record;
  } rec_t;

  // Record after the usage sum and importance are formed
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              live;
    logic              skip;
    logic [PRIO_W-1:0] priority_level;
    logic [IMP_W-1:0]  importance;
    logic [BYTE_W-1:0] total_bytes;
    logic [BYTE_W-1:0] minimum_bytes;
    logic [BYTE_W-1:0] reclaimable_bytes;
    logic [BYTE_W-1:0] soft_limit_bytes;
    logic [CEIL_W-1:0] importance_ceiling;
    logic              last_record;
  } sum_t;

  // Qualified donor candidate
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [IMP_W-1:0]  importance;
    logic              over_soft;
    logic [BYTE_W-1:0] available;
    logic              eligible;
    logic              last_record;
  } cand_t;

endpackage

// ----- src/rds_prep.sv -----
// ---------------------------------------------------------------------------
// Reclaim donor selector: usage stage
// Forms the saturated total usage and the importance weight of a record.
// ---------------------------------------------------------------------------
module rds_prep (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  rds_pkg::rec_t up_rec,
  output logic          up_ready,
  output logic          dn_valid,
  output rds_pkg::sum_t dn_sum,
  input  logic          dn_ready
);

  logic                        valid_r;
  rds_pkg::sum_t               sum_r;
  rds_pkg::sum_t               sum_nxt;
  logic [rds_pkg::BYTE_W:0]    raw_sum;
  logic [rds_pkg::IMP_W-1:0]   imp;

  // Saturating add of managed and observed bytes
  assign raw_sum = {1'b0, up_rec.managed_bytes} + {1'b0, up_rec.observed_bytes};

  // Importance is priority*16 + activity*4
  assign imp = rds_pkg::IMP_W'(up_rec.priority_level) * rds_pkg::IMP_W'(rds_pkg::PRIO_WEIGHT)
             + rds_pkg::IMP_W'(up_rec.activity_level) * rds_pkg::IMP_W'(rds_pkg::ACT_WEIGHT);

  always_comb begin
    sum_nxt.slot               = up_rec.slot;
    sum_nxt.live               = up_rec.live;
    sum_nxt.skip               = up_rec.skip;
    sum_nxt.priority_level     = up_rec.priority_level;
    sum_nxt.importance         = imp;
    sum_nxt.total_bytes        = raw_sum[rds_pkg::BYTE_W] ? '1 : raw_sum[rds_pkg::BYTE_W-1:0];
    sum_nxt.minimum_bytes      = up_rec.minimum_bytes;
    sum_nxt.reclaimable_bytes  = up_rec.reclaimable_bytes;
    sum_nxt.soft_limit_bytes   = up_rec.soft_limit_bytes;
    sum_nxt.importance_ceiling = up_rec.importance_ceiling;
    sum_nxt.last_record        = up_rec.last_record;
  end

  // Take a new item when empty or when the next stage drains this one
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sum_r <= sum_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_sum   = sum_r;

endmodule

// ----- src/rds_qualify.sv -----
// ---------------------------------------------------------------------------
// Reclaim donor selector: qualify stage
// Works out the reclaimable amount, soft-limit status and eligibility.
// ---------------------------------------------------------------------------
module rds_qualify (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rds_pkg::PRIO_W-1:0] crit_code,
  input  logic                      up_valid,
  input  rds_pkg::sum_t             up_sum,
  output logic                      up_ready,
  output logic                      dn_valid,
  output rds_pkg::cand_t            dn_cand,
  input  logic                      dn_ready
);

  logic                          valid_r;
  rds_pkg::cand_t                cand_r;
  rds_pkg::cand_t                cand_nxt;
  logic [rds_pkg::BYTE_W:0]      diff;
  logic [rds_pkg::BYTE_W-1:0]    above;
  logic                          above_min;
  logic                          slot_ok;
  logic                          ceil_ok;

  // Headroom above the minimum; borrow means total is below it
  assign diff      = {1'b0, up_sum.total_bytes} - {1'b0, up_sum.minimum_bytes};
  assign above     = diff[rds_pkg::BYTE_W-1:0];
  assign above_min = !diff[rds_pkg::BYTE_W] && (above != '0);

  assign slot_ok = (int'(up_sum.slot) < rds_pkg::SLOTS);
  assign ceil_ok = (up_sum.importance_ceiling == rds_pkg::CEILING_OFF) ||
                   ({1'b0, up_sum.importance} < up_sum.importance_ceiling);

  always_comb begin
    cand_nxt.slot        = up_sum.slot;
    cand_nxt.importance  = up_sum.importance;
    cand_nxt.over_soft   = (up_sum.soft_limit_bytes != '0) &&
                           (up_sum.total_bytes > up_sum.soft_limit_bytes);
    cand_nxt.available   = '0;
    if (above_min) begin
      cand_nxt.available = (up_sum.reclaimable_bytes < above) ? up_sum.reclaimable_bytes
                                                               : above;
    end
    // Nonzero available means headroom exists and reclaimable is nonzero
    cand_nxt.eligible    = up_sum.live && !up_sum.skip &&
                           (up_sum.priority_level != crit_code) &&
                           above_min && (up_sum.reclaimable_bytes != '0) &&
                           slot_ok && ceil_ok;
    cand_nxt.last_record = up_sum.last_record;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cand_r <= cand_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_cand  = cand_r;

endmodule

// ----- src/rds_track.sv -----
// ---------------------------------------------------------------------------
// Reclaim donor selector: tracking stage
// Holds the running best donor and drives the result register.
// ---------------------------------------------------------------------------
module rds_track (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  rds_pkg::cand_t             up_cand,
  output logic                       up_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [rds_pkg::SLOT_W-1:0] out_donor_slot,
  output logic [rds_pkg::BYTE_W-1:0] out_donor_available
);

  logic                        best_valid_r;
  logic [rds_pkg::SLOT_W-1:0]  best_slot_r;
  logic [rds_pkg::IMP_W-1:0]   best_imp_r;
  logic                        best_over_r;
  logic [rds_pkg::BYTE_W-1:0]  best_avail_r;

  logic                        best_valid_nxt;
  logic [rds_pkg::SLOT_W-1:0]  best_slot_nxt;
  logic [rds_pkg::IMP_W-1:0]   best_imp_nxt;
  logic                        best_over_nxt;
  logic [rds_pkg::BYTE_W-1:0]  best_avail_nxt;

  logic                        out_valid_r;
  logic                        found_r;
  logic [rds_pkg::SLOT_W-1:0]  slot_r;
  logic [rds_pkg::BYTE_W-1:0]  avail_r;

  logic                        take;
  logic                        emit;
  logic                        same_imp;
  logic                        better;

  // A last item needs the result register free; others are always absorbed
  assign up_ready = !up_cand.last_record || !out_valid_r || !out_stall;
  assign take     = up_valid && up_ready;
  assign emit     = take && up_cand.last_record;

  // Compare the candidate against the running best
  assign same_imp = (up_cand.importance == best_imp_r);
  assign better   = !best_valid_r ||
                    (up_cand.importance < best_imp_r) ||
                    (same_imp && up_cand.over_soft && !best_over_r) ||
                    (same_imp && (up_cand.over_soft == best_over_r) &&
                     (up_cand.available > best_avail_r));

  always_comb begin
    best_valid_nxt = best_valid_r;
    best_slot_nxt  = best_slot_r;
    best_imp_nxt   = best_imp_r;
    best_over_nxt  = best_over_r;
    best_avail_nxt = best_avail_r;
    if (take && up_cand.eligible && better) begin
      best_valid_nxt = 1'b1;
      best_slot_nxt  = up_cand.slot;
      best_imp_nxt   = up_cand.importance;
      best_over_nxt  = up_cand.over_soft;
      best_avail_nxt = up_cand.available;
    end
  end

  // Advance running best; clear it once the search result is taken
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      best_valid_r <= 1'b0;
      best_slot_r  <= '0;
      best_imp_r   <= '0;
      best_over_r  <= 1'b0;
      best_avail_r <= '0;
    end else begin
      best_valid_r <= best_valid_nxt;
      best_slot_r  <= best_slot_nxt;
      best_imp_r   <= best_imp_nxt;
      best_over_r  <= best_over_nxt;
      best_avail_r <= best_avail_nxt;
    end
  end

  // Result valid: set on emit, drop when taken downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load result payload from the updated best
  always_ff @(posedge clk) begin
    if (emit) begin
      found_r <= best_valid_nxt;
      slot_r  <= best_valid_nxt ? best_slot_nxt : '0;
      avail_r <= best_valid_nxt ? best_avail_nxt : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = found_r;
  assign out_donor_slot      = slot_r;
  assign out_donor_available = avail_r;

endmodule

// ----- src/reclaim_donor_selector.sv -----
// A result reaches the out_ channel through the input, usage, qualify and result registers.
// Throughput: one record per cycle unless in_stall; a record may follow in the next cycle.
// in_stall rises only when the input, usage and qualify registers are all full
// behind a last record whose result register is still held by out_stall.
// Reset (rst_n low, synchronous) clears the pipeline, the running best and the
// critical priority code; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Reclaim donor selector
// Streams client records through a four-register pipeline and reports the
// best reclaim donor of each search on its last record.
// ---------------------------------------------------------------------------
module reclaim_donor_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rds_pkg::PRIO_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rds_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        in_live,
  input  logic                        in_skip,
  input  logic [rds_pkg::PRIO_W-1:0]  in_priority_level,
  input  logic [rds_pkg::ACT_W-1:0]   in_activity_level,
  input  logic [rds_pkg::BYTE_W-1:0]  in_managed_bytes,
  input  logic [rds_pkg::BYTE_W-1:0]  in_observed_bytes,
  input  logic [rds_pkg::BYTE_W-1:0]  in_minimum_bytes,
  input  logic [rds_pkg::BYTE_W-1:0]  in_reclaimable_bytes,
  input  logic [rds_pkg::BYTE_W-1:0]  in_soft_limit_bytes,
  input  logic [rds_pkg::CEIL_W-1:0]  in_importance_ceiling,
  input  logic                        in_last_record,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [rds_pkg::SLOT_W-1:0]  out_donor_slot,
  output logic [rds_pkg::BYTE_W-1:0]  out_donor_available
);

  logic [rds_pkg::PRIO_W-1:0] crit_code_r;
  logic                       in_valid_r;
  rds_pkg::rec_t              rec_r;
  rds_pkg::rec_t              rec_nxt;
  logic                       in_ready;
  logic                       prep_ready;
  logic                       prep_valid;
  rds_pkg::sum_t              prep_sum;
  logic                       qual_ready;
  logic                       qual_valid;
  rds_pkg::cand_t             qual_cand;
  logic                       track_ready;

  // Hold the critical priority code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_code_r <= '0;
    end else if (cfg_wr_en) begin
      crit_code_r <= cfg_wr_data;
    end
  end

  // Gather input ports into one record
  always_comb begin
    rec_nxt.slot               = in_slot;
    rec_nxt.live               = in_live;
    rec_nxt.skip               = in_skip;
    rec_nxt.priority_level     = in_priority_level;
    rec_nxt.activity_level     = in_activity_level;
    rec_nxt.managed_bytes      = in_managed_bytes;
    rec_nxt.observed_bytes     = in_observed_bytes;
    rec_nxt.minimum_bytes      = in_minimum_bytes;
    rec_nxt.reclaimable_bytes  = in_reclaimable_bytes;
    rec_nxt.soft_limit_bytes   = in_soft_limit_bytes;
    rec_nxt.importance_ceiling = in_importance_ceiling;
    rec_nxt.last_record        = in_last_record;
  end

  // Input register
  assign in_ready = !in_valid_r || prep_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rec_r <= rec_nxt;
    end
  end

  rds_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_rec   (rec_r),
    .up_ready (prep_ready),
    .dn_valid (prep_valid),
    .dn_sum   (prep_sum),
    .dn_ready (qual_ready)
  );

  rds_qualify u_qualify (
    .clk       (clk),
    .rst_n     (rst_n),
    .crit_code (crit_code_r),
    .up_valid  (prep_valid),
    .up_sum    (prep_sum),
    .up_ready  (qual_ready),
    .dn_valid  (qual_valid),
    .dn_cand   (qual_cand),
    .dn_ready  (track_ready)
  );

  rds_track u_track (
    .clk                 (clk),
    .rst_n               (rst_n),
    .up_valid            (qual_valid),
    .up_cand             (qual_cand),
    .up_ready            (track_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_donor_slot      (out_donor_slot),
    .out_donor_available (out_donor_available)
  );

`ifndef SYNTHESIS
  // No donor means zero slot and zero amount
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_donor_slot == '0 && out_donor_available == '0))
    else $error("empty result carries nonzero slot or amount");

  // A chosen donor always has something to give
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_donor_available != '0))
    else $error("chosen donor has zero available bytes");

  // Input stalls only when every pipeline register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && prep_valid && qual_valid && qual_cand.last_record))
    else $error("input stalled with a free pipeline register");
`endif

endmodule
